### rtl/pfs_pkg.sv
`default_nettype none

package pfs_pkg;

    // Geometry of the key square.
    localparam int SQ_DIM   = 6;
    localparam int SQ_SIZE  = SQ_DIM * SQ_DIM;
    localparam int CODE_W   = 6;
    localparam int POS_W    = 3;

    // Key register widths and the packed square.
    localparam int KEY_W      = 60;
    localparam int KEY3_W     = 36;
    localparam int SQUARE_W   = SQ_SIZE * CODE_W;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD_0 = 2'd0,
        REG_KEY_WORD_1 = 2'd1,
        REG_KEY_WORD_2 = 2'd2,
        REG_KEY_WORD_3 = 2'd3
    } cfg_reg_t;

    // Row and column of one square entry.
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

    typedef logic [SQ_SIZE-1:0]  match_t;
    typedef logic [SQUARE_W-1:0] square_t;
    typedef logic [CODE_W-1:0]   code_t;

endpackage

`default_nettype wire

### rtl/playfair_pair_substitution_unit.sv
`default_nettype none

// Playfair pair substitution over a 6x6 key square held in four key registers.
//
// Channels: the input channel carries first_symbol, second_symbol, lone_symbol
// and decrypt under in_valid/in_stall; the result channel carries out_first,
// out_second, out_second_valid and not_found under out_valid/out_stall. A
// transaction completes on a rising edge where valid is high and stall is low.
// The key square is loaded through cfg_valid/cfg_ready with cfg_index selecting
// key_word_0..key_word_3; cfg_ready is always high. Load the key only while no
// transaction is in flight.
//
// A new pair is accepted every cycle while in_stall is low. The four register
// stages, ending in the output register, are: entry compare, lowest-match
// priority encode, Playfair move, square read.
//
// Reset clears all valid bits and the key registers (an all-zero square). When
// the receiver stalls a valid result, the whole pipeline freezes and in_stall
// is raised; nothing is dropped or repeated.

module playfair_pair_substitution_unit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pfs_pkg::KEY_W-1:0]         cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [pfs_pkg::CODE_W-1:0]        first_symbol,
    input  wire logic [pfs_pkg::CODE_W-1:0]        second_symbol,
    input  wire logic                              lone_symbol,
    input  wire logic                              decrypt,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [pfs_pkg::CODE_W-1:0]             out_first,
    output logic [pfs_pkg::CODE_W-1:0]             out_second,
    output logic                                   out_second_valid,
    output logic                                   not_found
);

    // ------------------------------------------------------------------
    // Key registers
    // ------------------------------------------------------------------
    logic [pfs_pkg::KEY_W-1:0]  key0_reg;
    logic [pfs_pkg::KEY_W-1:0]  key1_reg;
    logic [pfs_pkg::KEY_W-1:0]  key2_reg;
    logic [pfs_pkg::KEY3_W-1:0] key3_reg;
    pfs_pkg::square_t           square;

    assign cfg_ready = 1'b1;
    assign square    = {key3_reg, key2_reg, key1_reg, key0_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (pfs_pkg::cfg_reg_t'(cfg_index))
                pfs_pkg::REG_KEY_WORD_0: key0_reg <= cfg_data;
                pfs_pkg::REG_KEY_WORD_1: key1_reg <= cfg_data;
                pfs_pkg::REG_KEY_WORD_2: key2_reg <= cfg_data;
                pfs_pkg::REG_KEY_WORD_3: key3_reg <= cfg_data[pfs_pkg::KEY3_W-1:0];
                default:                 key0_reg <= key0_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Lowest matching entry wins, so duplicates resolve to the first one.
    function automatic pfs_pkg::pos_t encode_lowest(pfs_pkg::match_t m);
        pfs_pkg::pos_t p;
        p = '0;
        for (int r = pfs_pkg::SQ_DIM - 1; r >= 0; r--)
        begin
            for (int c = pfs_pkg::SQ_DIM - 1; c >= 0; c--)
            begin
                if (m[r * pfs_pkg::SQ_DIM + c])
                begin
                    p.row = pfs_pkg::POS_W'(r);
                    p.col = pfs_pkg::POS_W'(c);
                end
            end
        end
        return p;
    endfunction

    // One step around the square, wrapping at either edge.
    function automatic logic [pfs_pkg::POS_W-1:0] wrap_step(logic [pfs_pkg::POS_W-1:0] v,
                                                           logic back);
        logic [pfs_pkg::POS_W-1:0] res;
        if (back)
            res = (v == '0) ? pfs_pkg::POS_W'(pfs_pkg::SQ_DIM - 1) : v - 1'b1;
        else
            res = (v == pfs_pkg::POS_W'(pfs_pkg::SQ_DIM - 1)) ? '0 : v + 1'b1;
        return res;
    endfunction

    function automatic pfs_pkg::code_t cell_at(pfs_pkg::square_t sq, pfs_pkg::pos_t p);
        pfs_pkg::code_t v;
        v = '0;
        for (int r = 0; r < pfs_pkg::SQ_DIM; r++)
        begin
            for (int c = 0; c < pfs_pkg::SQ_DIM; c++)
            begin
                if (p.row == pfs_pkg::POS_W'(r) && p.col == pfs_pkg::POS_W'(c))
                    v = sq[(r * pfs_pkg::SQ_DIM + c) * pfs_pkg::CODE_W +: pfs_pkg::CODE_W];
            end
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves unless a result is held.
    // ------------------------------------------------------------------
    logic advance;

    logic v1_reg, v2_reg, v3_reg, out_valid_reg;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: compare both symbols against all 36 entries.
    // ------------------------------------------------------------------
    pfs_pkg::match_t m1_next, m2_next;
    pfs_pkg::match_t m1_reg, m2_reg;
    logic            lone1_reg, dec1_reg;

    always_comb
    begin
        for (int i = 0; i < pfs_pkg::SQ_SIZE; i++)
        begin
            m1_next[i] = (square[i * pfs_pkg::CODE_W +: pfs_pkg::CODE_W] == first_symbol);
            m2_next[i] = (square[i * pfs_pkg::CODE_W +: pfs_pkg::CODE_W] == second_symbol);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: encode positions and found flags.
    // ------------------------------------------------------------------
    pfs_pkg::pos_t p1_next, p2_next;
    pfs_pkg::pos_t p1_reg, p2_reg;
    logic          nf2_next;
    logic          nf2_reg, lone2_reg, dec2_reg;

    assign p1_next  = encode_lowest(m1_reg);
    assign p2_next  = encode_lowest(m2_reg);
    assign nf2_next = !(|m1_reg) || (!lone1_reg && !(|m2_reg));

    // ------------------------------------------------------------------
    // Stage 3: apply the Playfair rule to get the target cells.
    // ------------------------------------------------------------------
    pfs_pkg::pos_t t1_next, t2_next;
    pfs_pkg::pos_t t1_reg, t2_reg;
    logic          nf3_reg, lone3_reg;

    always_comb
    begin
        if (lone2_reg)
        begin
            t1_next = '{row: wrap_step(p1_reg.row, dec2_reg), col: p1_reg.col};
            t2_next = p2_reg;
        end
        else if (p1_reg.row != p2_reg.row && p1_reg.col != p2_reg.col)
        begin
            // Rectangle: swap columns.
            t1_next = '{row: p1_reg.row, col: p2_reg.col};
            t2_next = '{row: p2_reg.row, col: p1_reg.col};
        end
        else if (p1_reg.row == p2_reg.row && p1_reg.col != p2_reg.col)
        begin
            t1_next = '{row: p1_reg.row, col: wrap_step(p1_reg.col, dec2_reg)};
            t2_next = '{row: p2_reg.row, col: wrap_step(p2_reg.col, dec2_reg)};
        end
        else
        begin
            // Same column or the very same entry: move vertically.
            t1_next = '{row: wrap_step(p1_reg.row, dec2_reg), col: p1_reg.col};
            t2_next = '{row: wrap_step(p2_reg.row, dec2_reg), col: p2_reg.col};
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: read the square and form the result.
    // ------------------------------------------------------------------
    pfs_pkg::code_t out_first_next, out_second_next;
    pfs_pkg::code_t out_first_reg, out_second_reg;
    logic           out_second_valid_next, out_second_valid_reg, not_found_reg;

    assign out_first_next        = nf3_reg ? '0 : cell_at(square, t1_reg);
    assign out_second_next       = (nf3_reg || lone3_reg) ? '0 : cell_at(square, t2_reg);
    assign out_second_valid_next = !nf3_reg && !lone3_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_reg               <= m1_next;
            m2_reg               <= m2_next;
            lone1_reg            <= lone_symbol;
            dec1_reg             <= decrypt;

            p1_reg               <= p1_next;
            p2_reg               <= p2_next;
            nf2_reg              <= nf2_next;
            lone2_reg            <= lone1_reg;
            dec2_reg             <= dec1_reg;

            t1_reg               <= t1_next;
            t2_reg               <= t2_next;
            nf3_reg              <= nf2_reg;
            lone3_reg            <= lone2_reg;

            out_first_reg        <= out_first_next;
            out_second_reg       <= out_second_next;
            out_second_valid_reg <= out_second_valid_next;
            not_found_reg        <= nf3_reg;
        end
    end

    assign out_first        = out_first_reg;
    assign out_second       = out_second_reg;
    assign out_second_valid = out_second_valid_reg;
    assign not_found        = not_found_reg;

`ifndef ASSERT_OFF
    // The input is held back only while a finished result waits.
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall raised without a held result");

    // A missing symbol yields no substituted symbols.
    a_not_found_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && not_found) |-> (out_first == '0 && out_second == '0
                                      && !out_second_valid))
        else $error("not_found result carries symbol data");

    // An accepted pair with a free output path reaches the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
        else $error("accepted transaction did not reach the output");
`endif

endmodule

`default_nettype wire
